// ----- src/lob_pkg.sv -----
// Shared constants, codes and structs of the limit order book.
package lob_pkg;

	localparam int ORDER_SLOTS     = 1024;
	localparam int LEVELS_PER_SIDE = 256;
	localparam int AW   = $clog2(ORDER_SLOTS);
	localparam int CW   = AW + 1;
	localparam int LCW  = $clog2(LEVELS_PER_SIDE + 1);
	localparam int IDW  = 64;
	localparam int PW   = 32;
	localparam int QW   = 32;
	localparam int TW   = 42;
	localparam int OPW  = 3;
	localparam int STW  = 3;
	localparam int IN_DW  = 200;
	localparam int OUT_DW = 192;

	typedef enum logic [OPW-1:0] {
		OP_ADD     = 3'd0,
		OP_CANCEL  = 3'd1,
		OP_EXECUTE = 3'd2,
		OP_REPLACE = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	typedef enum logic [STW-1:0] {
		ST_OK        = 3'd0,
		ST_DUP       = 3'd1,
		ST_POOL_FULL = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_IGNORED   = 3'd4,
		ST_LVL_FULL  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_A,
		S_SCAN_B,
		S_APPLY,
		S_SCAN_C,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PASS_A,
		PASS_B,
		PASS_C
	} pass_t;

	typedef enum logic [1:0] {
		LVL_HOLD,
		LVL_INC,
		LVL_DEC
	} lvl_op_t;

	typedef struct packed {
		logic          valid;
		logic          side;
		logic [IDW-1:0] id;
		logic [PW-1:0]  price;
		logic [QW-1:0]  qty;
	} entry_t;

	typedef struct packed {
		logic          rd_en;
		logic          wr_clr;
		logic [AW-1:0] addr;
		pass_t         pass;
		logic          load_in;
		logic          apply;
		logic          load_out;
	} cmd_t;

endpackage

// ----- src/limit_order_book.sv -----
// Top level: price-time priority limit order book with a stream in and a stream out.
// An accepted word runs through three one-slot-per-cycle passes over the single-port
//   order store, with the update applied between the second and the third pass.
// One word is in work at a time.
// Reset: arst_n clears control at once, then a clearing pass empties the store;
//   s_tready stays low until it ends.
module limit_order_book (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lob_pkg::IN_DW-1:0]  s_tdata,  // id, replacement id, side, price, quantity, pad
	input  logic [lob_pkg::OPW-1:0]    s_tuser,  // operation
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lob_pkg::OUT_DW-1:0] m_tdata,  // level_total, bid_valid, best_bid_price,
	                                             // best_bid_total, ask_valid, best_ask_price,
	                                             // best_ask_total
	output logic [lob_pkg::STW-1:0]    m_tuser   // status
);
	import lob_pkg::*;

	cmd_t cmd;

	lob_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lob_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_op      (s_tuser),
		.in_data    (s_tdata),
		.out_status (m_tuser),
		.out_data   (m_tdata)
	);

endmodule

// ----- src/lob_ctrl.sv -----
// Sequencer: clearing pass, three scans over the order store, update and result handoff.
module lob_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output lob_pkg::cmd_t cmd
);
	import lob_pkg::*;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          ovalid_q;
	logic          last;

	assign last     = (cnt_q == CW'(ORDER_SLOTS));
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (last) state_d = S_IDLE;
			S_IDLE:   if (s_tvalid) state_d = S_SCAN_A;
			S_SCAN_A: if (last) state_d = S_SCAN_B;
			S_SCAN_B: if (last) state_d = S_APPLY;
			S_APPLY:  state_d = S_SCAN_C;
			S_SCAN_C: if (last) state_d = S_DONE;
			S_DONE:   if (!ovalid_q || m_tready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.addr     = cnt_q[AW-1:0];
		cmd.pass     = PASS_A;
		unique case (state_q)
			S_CLEAR:  cmd.wr_clr = !last;
			S_IDLE:   cmd.load_in = s_tvalid;
			S_SCAN_A: cmd.rd_en = !last;
			S_SCAN_B: begin
				cmd.rd_en = !last;
				cmd.pass  = PASS_B;
			end
			S_APPLY:  cmd.apply = 1'b1;
			S_SCAN_C: begin
				cmd.rd_en = !last;
				cmd.pass  = PASS_C;
			end
			S_DONE:   cmd.load_out = !ovalid_q || m_tready;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// one extra step per pass lets the last read word land
			if ((state_q == S_CLEAR || state_q == S_SCAN_A || state_q == S_SCAN_B ||
			     state_q == S_SCAN_C) && !last)
				cnt_q <= cnt_q + CW'(1);
			else
				cnt_q <= '0;
			if (cmd.load_out)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

endmodule

// ----- src/lob_dp.sv -----
// Datapath: order store, scan accumulators, level counters and the update decision.
module lob_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lob_pkg::cmd_t             cmd,
	input  logic [lob_pkg::OPW-1:0]   in_op,
	input  logic [lob_pkg::IN_DW-1:0] in_data,
	output logic [lob_pkg::STW-1:0]   out_status,
	output logic [lob_pkg::OUT_DW-1:0] out_data
);
	import lob_pkg::*;

	entry_t        mem [ORDER_SLOTS];
	entry_t        rd_s1;
	logic          rdv_s1;
	pass_t         pass_s1;
	logic [AW-1:0] idx_s1;

	logic [OPW-1:0] op_q;
	logic [IDW-1:0] id_q, nid_q;
	logic           side_q;
	logic [PW-1:0]  price_q;
	logic [QW-1:0]  qty_q;

	// pass A: id and replacement id lookup and first free slot
	logic           hit_q, nhit_q, free_q;
	logic [AW-1:0]  hidx_q, fidx_q;
	entry_t         hent_q;
	// pass B: presence at the two prices of interest and the quantity total at the first
	logic [1:0]     cnta_q, cntb_q;
	logic [TW-1:0]  suma_q;
	// pass C: best levels
	logic           bidv_q, askv_q;
	logic [PW-1:0]  bp_q, ap_q;
	logic [TW-1:0]  bt_q, at_q;

	logic [LCW-1:0] lc_q [2];
	logic [STW-1:0] st_q, ost_q;
	logic [TW-1:0]  lt_q, olt_q;
	logic [OUT_DW-1:0] obest_q;

	logic           use_e, bside;
	logic [PW-1:0]  pa;
	logic           match_a, match_b;
	logic [TW-1:0]  rqty;

	status_t        st_d;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	entry_t         wr_data;
	lvl_op_t        lc_act;
	logic           full_s;

	assign use_e = (op_q == OP_CANCEL) || (op_q == OP_EXECUTE) || (op_q == OP_REPLACE);
	assign bside = use_e ? hent_q.side : side_q;
	assign pa    = use_e ? hent_q.price : price_q;
	assign match_a = rd_s1.valid && (rd_s1.side == bside) && (rd_s1.price == pa);
	assign match_b = rd_s1.valid && (rd_s1.side == bside) && (rd_s1.price == price_q);
	assign rqty    = {{(TW-QW){1'b0}}, rd_s1.qty};
	assign full_s  = (lc_q[bside] == LCW'(LEVELS_PER_SIDE));

	always_comb begin
		st_d    = ST_IGNORED;
		wr_en   = 1'b0;
		wr_addr = hidx_q;
		wr_data = hent_q;
		lc_act  = LVL_HOLD;
		unique case (op_q)
			OP_ADD: begin
				if (hit_q) begin
					st_d = ST_DUP;
				end else if (!free_q) begin
					st_d = ST_POOL_FULL;
				end else if (cnta_q == 2'd0 && full_s) begin
					st_d = ST_LVL_FULL;
				end else begin
					st_d    = ST_OK;
					wr_en   = 1'b1;
					wr_addr = fidx_q;
					wr_data = '{valid: 1'b1, side: side_q, id: id_q, price: price_q, qty: qty_q};
					if (cnta_q == 2'd0) lc_act = LVL_INC;
				end
			end
			OP_CANCEL, OP_EXECUTE: begin
				if (hit_q) begin
					st_d  = ST_OK;
					wr_en = 1'b1;
					if (op_q == OP_CANCEL || qty_q >= hent_q.qty) begin
						wr_data.valid = 1'b0;
						if (cnta_q == 2'd1) lc_act = LVL_DEC;
					end else begin
						wr_data.qty = hent_q.qty - qty_q;
					end
				end
			end
			OP_REPLACE: begin
				if (!hit_q) begin
					st_d = ST_NOT_FOUND;
				end else if (nid_q != id_q && nhit_q) begin
					st_d = ST_DUP;
				end else if (price_q != hent_q.price && cntb_q == 2'd0 && cnta_q != 2'd1 &&
				             full_s) begin
					st_d = ST_LVL_FULL;
				end else begin
					st_d  = ST_OK;
					wr_en = 1'b1;
					wr_data.id    = nid_q;
					wr_data.price = price_q;
					wr_data.qty   = qty_q;
					if (price_q != hent_q.price) begin
						if (cntb_q != 2'd0 && cnta_q == 2'd1) lc_act = LVL_DEC;
						else if (cntb_q == 2'd0 && cnta_q != 2'd1) lc_act = LVL_INC;
					end
				end
			end
			OP_QUERY: st_d = ST_OK;
			default:  st_d = ST_IGNORED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_clr)
			mem[cmd.addr] <= '0;
		else if (cmd.apply && wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_s1 <= mem[cmd.addr];
		idx_s1  <= cmd.addr;
		pass_s1 <= cmd.pass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
			lc_q[0] <= '0;
			lc_q[1] <= '0;
		end else begin
			rdv_s1 <= cmd.rd_en;
			if (cmd.apply && lc_act == LVL_INC)
				lc_q[bside] <= lc_q[bside] + LCW'(1);
			else if (cmd.apply && lc_act == LVL_DEC)
				lc_q[bside] <= lc_q[bside] - LCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= in_op;
			id_q    <= in_data[63:0];
			nid_q   <= in_data[127:64];
			side_q  <= in_data[128];
			price_q <= in_data[160:129];
			qty_q   <= in_data[192:161];
			hit_q   <= 1'b0;
			nhit_q  <= 1'b0;
			free_q  <= 1'b0;
			cnta_q  <= '0;
			cntb_q  <= '0;
			suma_q  <= '0;
			bidv_q  <= 1'b0;
			askv_q  <= 1'b0;
			bp_q    <= '0;
			ap_q    <= '0;
			bt_q    <= '0;
			at_q    <= '0;
		end else if (rdv_s1) begin
			unique case (pass_s1)
				PASS_A: begin
					if (rd_s1.valid && rd_s1.id == id_q && !hit_q) begin
						hit_q  <= 1'b1;
						hidx_q <= idx_s1;
						hent_q <= rd_s1;
					end
					if (rd_s1.valid && rd_s1.id == nid_q)
						nhit_q <= 1'b1;
					if (!rd_s1.valid && !free_q) begin
						free_q <= 1'b1;
						fidx_q <= idx_s1;
					end
				end
				PASS_B: begin
					if (match_a) begin
						suma_q <= suma_q + rqty;
						if (cnta_q != 2'd2) cnta_q <= cnta_q + 2'd1;
					end
					if (match_b && cntb_q != 2'd2)
						cntb_q <= cntb_q + 2'd1;
				end
				PASS_C: begin
					if (rd_s1.valid && !rd_s1.side) begin
						if (!bidv_q || rd_s1.price > bp_q) begin
							bidv_q <= 1'b1;
							bp_q   <= rd_s1.price;
							bt_q   <= rqty;
						end else if (rd_s1.price == bp_q) begin
							bt_q <= bt_q + rqty;
						end
					end
					if (rd_s1.valid && rd_s1.side) begin
						if (!askv_q || rd_s1.price < ap_q) begin
							askv_q <= 1'b1;
							ap_q   <= rd_s1.price;
							at_q   <= rqty;
						end else if (rd_s1.price == ap_q) begin
							at_q <= at_q + rqty;
						end
					end
				end
				default: ;
			endcase
		end
		if (cmd.apply) begin
			st_q <= st_d;
			lt_q <= (op_q == OP_QUERY) ? suma_q : '0;
		end
		if (cmd.load_out) begin
			ost_q   <= st_q;
			olt_q   <= lt_q;
			obest_q <= {at_q, ap_q, askv_q, bt_q, bp_q, bidv_q, {TW{1'b0}}};
		end
	end

	assign out_status = ost_q;
	assign out_data   = {obest_q[OUT_DW-1:TW], olt_q};

endmodule

// ----- src/lob_checker.sv -----
// Port-level checks of the limit order book, bound to the top level.
module lob_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [lob_pkg::OUT_DW-1:0] m_tdata,
	input logic [lob_pkg::STW-1:0]    m_tuser
);
	import lob_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= STW'(ST_LVL_FULL))
		else $error("status code out of range");

	a_no_bid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[42] |-> m_tdata[74:43] == '0 && m_tdata[116:75] == '0)
		else $error("best bid reported without a bid level");

endmodule

bind limit_order_book lob_checker u_lob_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
